FILE: rtl/core/plbs_pkg.sv
// ----------------------------------------------------------------------------
// plbs_pkg
// Types and constants shared by the brightness loop core and its multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package plbs_pkg;

  localparam int ACC_W   = 48;
  localparam int DUTY_W  = 23;
  localparam int ERR_W   = 17;
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // 100 percent in Q.16
  localparam logic [DUTY_W-1:0] DUTY_FULL = 23'd6553600;

  localparam logic [CFG_IDX_W-1:0] CFG_LUX_SETPOINT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_GAIN_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHANGE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_THRESHOLD = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INT,
    S_ACC,
    S_PI,
    S_CHG,
    S_FLT,
    S_DCY,
    S_UPD
  } state_t;

  typedef struct packed {
    logic                      en;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_op_t;

endpackage

`default_nettype wire

FILE: rtl/core/plbs_mul.sv
// ----------------------------------------------------------------------------
// plbs_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module plbs_mul (
  input  wire logic                                   clk,
  input  wire plbs_pkg::mul_op_t                      op,
  output      logic signed [plbs_pkg::MUL_P_W-1:0]    prod_r
);
  import plbs_pkg::*;

  logic signed [MUL_P_W-1:0] prod_nxt;

  always_comb begin
    prod_nxt = op.a * op.b;
  end

  always_ff @(posedge clk) begin
    if (op.en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pi_brightness_loop_with_slew_unit.sv
// ----------------------------------------------------------------------------
// pi_brightness_loop_with_slew_unit
// PI brightness loop with anti-windup, slew limit and smoothed duty output.
// ----------------------------------------------------------------------------
// Each accepted item is one control tick and yields one result item. With a
// nonzero setpoint the tick runs the PI step and the slew-limited filter
// through the steps integral product, PI product, clamp, slew limit, filter
// product and update, and the sequencer returns to idle before the next item
// can be taken. With the setpoint at zero the decay path runs the decay
// product and then the update. Every product goes through the one shared
// 33 x 25 bit multiplier. A stalled output register holds the sequencer in
// the update step. The input is taken only when the sequencer is idle; a
// finished result waits in the output register while the next item is
// accepted.
`default_nettype none

module pi_brightness_loop_with_slew_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [plbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [plbs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logic                                 in_valid,
  output      logic                                 in_stall,
  input  wire logic [15:0]                          in_measured_lux,
  output      logic                                 out_valid,
  input  wire logic                                 out_stall,
  output      logic [plbs_pkg::DUTY_W-1:0]          out_duty_out,
  output      logic                                 out_loop_active
);
  import plbs_pkg::*;

  localparam logic signed [49:0] SUM_MAX = 50'sd140737488355327;
  localparam logic signed [49:0] SUM_MIN = -50'sd140737488355328;

  // configuration registers
  logic [9:0]        lux_setpoint_r;
  logic [15:0]       prop_gain_r;
  logic [31:0]       int_gain_step_r;
  logic [DUTY_W-1:0] duty_max_r;
  logic [DUTY_W-1:0] max_change_r;
  logic [16:0]       filter_alpha_r;
  logic [DUTY_W-1:0] off_threshold_r;

  // loop state
  logic signed [ACC_W-1:0] integral_r;
  logic [DUTY_W-1:0]       smoothed_r;

  // sequencer and working registers
  state_t                  state_r, state_nxt;
  logic                    active_r, active_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [DUTY_W-1:0]       duty_pi_r, duty_pi_nxt;
  logic signed [24:0]      chg_r, chg_nxt;
  logic signed [ACC_W-1:0] integral_nxt;
  logic [DUTY_W-1:0]       smoothed_nxt;

  logic                    out_valid_r;
  logic [DUTY_W-1:0]       duty_out_r;
  logic                    loop_active_r;

  mul_op_t                   mul_op;
  logic signed [MUL_P_W-1:0] prod_r;

  logic in_accept;
  logic out_free;
  logic out_load;

  // datapath intermediates
  logic signed [49:0] sum_acc;
  logic signed [55:0] p_term;
  logic signed [55:0] pi_sum;
  logic signed [55:0] hi_56;
  logic signed [ACC_W-1:0] hi_48;
  logic signed [55:0] pi_cl;
  logic [DUTY_W-1:0]  duty_raw;
  logic signed [24:0] chg_raw;
  logic signed [24:0] mc_25;
  logic signed [MUL_P_W-1:0] prod_rnd;
  logic signed [29:0] rnd_30;
  logic signed [29:0] sd_30;
  logic signed [29:0] nd_pi;
  logic signed [29:0] nd_dec;
  logic [DUTY_W-1:0]  nd;

  plbs_mul u_mul (
    .clk    (clk),
    .op     (mul_op),
    .prod_r (prod_r)
  );

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = (lux_setpoint_r != 10'd0) ? S_INT : S_DCY;
        end
      end
      S_INT: state_nxt = S_ACC;
      S_ACC: state_nxt = S_PI;
      S_PI:  state_nxt = S_CHG;
      S_CHG: state_nxt = S_FLT;
      S_FLT: state_nxt = S_UPD;
      S_DCY: state_nxt = S_UPD;
      S_UPD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs: handshake and multiplier operands
  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    mul_op   = '0;
    unique case (state_r)
      S_IDLE: in_stall = 1'b0;
      S_INT: begin
        mul_op.en = 1'b1;
        mul_op.a  = $signed({1'b0, int_gain_step_r});
        mul_op.b  = $signed({{(MUL_B_W-ERR_W){err_r[ERR_W-1]}}, err_r});
      end
      S_ACC: begin
        mul_op.en = 1'b1;
        mul_op.a  = $signed({17'd0, prop_gain_r});
        mul_op.b  = $signed({{(MUL_B_W-ERR_W){err_r[ERR_W-1]}}, err_r});
      end
      S_FLT: begin
        mul_op.en = 1'b1;
        mul_op.a  = $signed({16'd0, filter_alpha_r});
        mul_op.b  = chg_r;
      end
      S_DCY: begin
        mul_op.en = 1'b1;
        mul_op.a  = $signed({16'd0, filter_alpha_r});
        mul_op.b  = $signed({2'b00, smoothed_r});
      end
      S_UPD: out_load = out_free;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // arithmetic between the multiplier steps
  always_comb begin
    err_nxt = $signed({7'd0, lux_setpoint_r}) - $signed({1'b0, in_measured_lux});

    // integrator add with saturation to 48 bits
    sum_acc = $signed({{2{integral_r[ACC_W-1]}}, integral_r}) + $signed(prod_r[49:0]);
    if (sum_acc > SUM_MAX) begin
      acc_nxt = SUM_MAX[ACC_W-1:0];
    end else if (sum_acc < SUM_MIN) begin
      acc_nxt = SUM_MIN[ACC_W-1:0];
    end else begin
      acc_nxt = sum_acc[ACC_W-1:0];
    end

    // PI sum, output clamp and anti-windup
    p_term = $signed({{2{prod_r[33]}}, prod_r[33:0], 20'd0});
    pi_sum = p_term + $signed({{8{acc_r[ACC_W-1]}}, acc_r});
    hi_56  = $signed({17'd0, duty_max_r, 16'd0});
    hi_48  = $signed({9'd0, duty_max_r, 16'd0});
    integral_nxt = acc_r;
    if (pi_sum > hi_56) begin
      pi_cl = hi_56;
      if (acc_r > hi_48) begin
        integral_nxt = hi_48;
      end
    end else if (pi_sum < 56'sd0) begin
      pi_cl = '0;
      if (acc_r < 48'sd0) begin
        integral_nxt = '0;
      end
    end else begin
      pi_cl = pi_sum;
    end
    duty_raw    = pi_cl[38:16];
    duty_pi_nxt = (duty_raw > DUTY_FULL) ? DUTY_FULL : duty_raw;

    // slew limit
    chg_raw = $signed({2'b00, duty_pi_r}) - $signed({2'b00, smoothed_r});
    mc_25   = $signed({2'b00, max_change_r});
    if (chg_raw > mc_25) begin
      chg_nxt = mc_25;
    end else if (chg_raw < -mc_25) begin
      chg_nxt = -mc_25;
    end else begin
      chg_nxt = chg_raw;
    end

    // round to nearest, halves up: floor((p + 2^15) / 2^16)
    prod_rnd = prod_r + 58'sd32768;
    rnd_30   = prod_rnd[45:16];
    sd_30    = $signed({7'd0, smoothed_r});
    nd_pi    = sd_30 + rnd_30;
    nd_dec   = sd_30 - rnd_30;

    if (active_r) begin
      if (nd_pi < 30'sd0) begin
        nd = '0;
      end else if (nd_pi > $signed({7'd0, DUTY_FULL})) begin
        nd = DUTY_FULL;
      end else begin
        nd = nd_pi[DUTY_W-1:0];
      end
    end else begin
      if (nd_dec < 30'sd0 || nd_dec < $signed({7'd0, off_threshold_r})) begin
        nd = '0;
      end else begin
        nd = nd_dec[DUTY_W-1:0];
      end
    end
    smoothed_nxt = nd;

    active_nxt = active_r;
    if (in_accept) begin
      active_nxt = (lux_setpoint_r != 10'd0);
    end
  end

  // control and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      active_r        <= 1'b0;
      integral_r      <= '0;
      smoothed_r      <= '0;
      lux_setpoint_r  <= 10'd0;
      prop_gain_r     <= 16'd2867;
      int_gain_step_r <= 32'd286331;
      duty_max_r      <= 23'd6553600;
      max_change_r    <= 23'd327680;
      filter_alpha_r  <= 17'd6554;
      off_threshold_r <= 23'd32768;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_PI) begin
        integral_r <= integral_nxt;
      end
      if (out_load) begin
        smoothed_r <= smoothed_nxt;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_LUX_SETPOINT:  lux_setpoint_r  <= cfg_wdata[9:0];
          CFG_PROP_GAIN:     prop_gain_r     <= cfg_wdata[15:0];
          CFG_INT_GAIN_STEP: int_gain_step_r <= cfg_wdata[31:0];
          CFG_DUTY_MAX:      duty_max_r      <= cfg_wdata[DUTY_W-1:0];
          CFG_MAX_CHANGE:    max_change_r    <= cfg_wdata[DUTY_W-1:0];
          CFG_FILTER_ALPHA:  filter_alpha_r  <= cfg_wdata[16:0];
          CFG_OFF_THRESHOLD: off_threshold_r <= cfg_wdata[DUTY_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      err_r <= err_nxt;
    end
    if (state_r == S_ACC) begin
      acc_r <= acc_nxt;
    end
    if (state_r == S_PI) begin
      duty_pi_r <= duty_pi_nxt;
    end
    if (state_r == S_CHG) begin
      chg_r <= chg_nxt;
    end
    if (out_load) begin
      duty_out_r    <= smoothed_nxt;
      loop_active_r <= active_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_duty_out    = duty_out_r;
  assign out_loop_active = loop_active_r;

`ifndef ASSERT_OFF
  // a result appears only from the update step
  a_out_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_UPD))
    else $error("result raised outside the update step");

  // duty never leaves 0..100 percent
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (duty_out_r <= DUTY_FULL))
    else $error("duty above full scale");

  // the decay path reaches the update step only through the decay product
  a_decay_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && !active_r) |->
      ($past(state_r) == S_DCY || $past(state_r) == S_UPD))
    else $error("decay update without decay product");

  // the integrator changes only in the clamp step of the PI path
  a_int_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(state_r) != S_PI) |-> $stable(integral_r))
    else $error("integrator changed outside the PI step");
`endif

endmodule

`default_nettype wire

FILE: sim/pi_brightness_loop_with_slew_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pi_brightness_loop_with_slew_unit_test
// Self-checking bench for the PI brightness loop with slew-limited duty.
// A driver feeds lux readings from a queue; each accepted item updates an
// in-bench copy of the integrator and smoothed duty, and the monitor compares
// every result item against the oldest prediction. Runs directed corner
// settings first, then randomised register sets with varied idle patterns.
// ----------------------------------------------------------------------------

module pi_brightness_loop_with_slew_unit_test;
  import plbs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam longint PCT_FULL = 6553600;
  localparam longint INTEG_HI = (longint'(1) <<< 47) - 1;
  localparam longint INTEG_LO = -(longint'(1) <<< 47);
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD = 300;
  localparam int RAND_PHASES = 13;
  localparam int PHASE_ITEMS = 110;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              active;
  } tick_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [15:0]           in_measured_lux;
  logic                  out_valid;
  logic                  out_stall;
  logic [DUTY_W-1:0]     out_duty_out;
  logic                  out_loop_active;

  pi_brightness_loop_with_slew_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_measured_lux (in_measured_lux),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_duty_out    (out_duty_out),
    .out_loop_active (out_loop_active)
  );

  // register copies
  logic [9:0]        setpoint_r;
  logic [15:0]       kp_r;
  logic [31:0]       ki_r;
  logic [DUTY_W-1:0] duty_max_r;
  logic [DUTY_W-1:0] slew_r;
  logic [16:0]       alpha_r;
  logic [DUTY_W-1:0] off_thr_r;

  // loop state, integrator in 2^-32 percent, duty in Q.16 percent
  longint integ_acc;
  longint smooth_duty;

  logic [15:0]  pending_lux[$];
  tick_result_t expected_duty[$];
  int           items_queued;
  int           results_seen;
  int           fail_count;
  int           active_seen;
  int           send_idle_pct;
  int           recv_stall_pct;
  bit           lux_taken;
  bit           hold_req;
  int           hold_left;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // floor of (p + half) / 2^16, so halves go up
  function automatic longint round_q16(longint p);
    return (p + 32768) >>> 16;
  endfunction

  function automatic tick_result_t compute_duty_tick(logic [15:0] lux);
    tick_result_t r;
    longint err, acc, hi, pi, duty_pi, delta, nd;
    if (setpoint_r != 0) begin
      err = longint'(setpoint_r) - longint'(lux);
      acc = integ_acc + longint'(ki_r) * err;
      if (acc > INTEG_HI) acc = INTEG_HI;
      if (acc < INTEG_LO) acc = INTEG_LO;
      hi = longint'(duty_max_r) * 65536;
      pi = longint'(kp_r) * err * 1048576 + acc;
      // anti-windup: integrator pulled back with the clamped output
      if (pi > hi) begin
        pi = hi;
        if (acc > hi) acc = hi;
      end else if (pi < 0) begin
        pi = 0;
        if (acc < 0) acc = 0;
      end
      integ_acc = acc;
      duty_pi = pi >>> 16;
      if (duty_pi > PCT_FULL) duty_pi = PCT_FULL;
      delta = duty_pi - smooth_duty;
      if (delta > longint'(slew_r)) delta = longint'(slew_r);
      if (delta < -longint'(slew_r)) delta = -longint'(slew_r);
      nd = smooth_duty + round_q16(longint'(alpha_r) * delta);
      if (nd < 0) nd = 0;
      if (nd > PCT_FULL) nd = PCT_FULL;
      r.active = 1'b1;
    end else begin
      nd = smooth_duty - round_q16(longint'(alpha_r) * smooth_duty);
      if (nd < 0) nd = 0;
      if (nd < longint'(off_thr_r)) nd = 0;
      r.active = 1'b0;
    end
    smooth_duty = nd & 64'h7FFFFF;
    r.duty = smooth_duty[DUTY_W-1:0];
    return r;
  endfunction

  // input side: new item only once the current one has gone
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || lux_taken) begin
      if (pending_lux.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_measured_lux <= pending_lux.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : monitor
    tick_result_t want;
    if (!rst_n) begin
      lux_taken = 1'b0;
    end else begin
      lux_taken = in_valid && !in_stall;
      if (lux_taken) expected_duty.push_back(compute_duty_tick(in_measured_lux));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_duty.size() == 0) begin
          $error("result item with nothing expected: duty_out %0d loop_active %0b",
                 out_duty_out, out_loop_active);
          fail_count++;
        end else begin
          want = expected_duty.pop_front();
          if (out_loop_active) active_seen++;
          if (out_duty_out !== want.duty) begin
            $error("duty_out: expected %0d, got %0d", want.duty, out_duty_out);
            fail_count++;
          end
          if (out_loop_active !== want.active) begin
            $error("loop_active: expected %0b, got %0b", want.active, out_loop_active);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_LUX_SETPOINT:  setpoint_r = data[9:0];
      CFG_PROP_GAIN:     kp_r = data[15:0];
      CFG_INT_GAIN_STEP: ki_r = data;
      CFG_DUTY_MAX:      duty_max_r = data[DUTY_W-1:0];
      CFG_MAX_CHANGE:    slew_r = data[DUTY_W-1:0];
      CFG_FILTER_ALPHA:  alpha_r = data[16:0];
      CFG_OFF_THRESHOLD: off_thr_r = data[DUTY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_lux(logic [15:0] v);
    pending_lux.push_back(v);
    items_queued++;
  endtask

  // wait until every queued item has come back, then let the core settle
  task automatic drain(int settle);
    while (results_seen != items_queued) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_val(logic [31:0] lo, logic [31:0] hi);
    int sel;
    sel = $urandom_range(99);
    if (sel < 15) return lo;
    if (sel < 30) return hi;
    return $urandom_range(hi, lo);
  endfunction

  // sometimes set bits above the register width, which must be dropped
  function automatic logic [31:0] with_junk(logic [31:0] v, int width);
    if ($urandom_range(3) == 0) return v | ($urandom() << width);
    return v;
  endfunction

  function automatic logic [15:0] pick_lux();
    int sel, v;
    sel = $urandom_range(99);
    if (sel < 70) begin
      v = int'(setpoint_r) + int'($urandom_range(80)) - 40;
      if (v < 0) v = 0;
      return v[15:0];
    end
    if (sel < 85) return 16'($urandom_range(16'hFFFF));
    if (sel < 92) return 16'($urandom_range(2000));
    return (sel < 96) ? 16'h0000 : 16'hFFFF;
  endfunction

  task automatic random_setup(bit loop_on);
    write_reg(CFG_LUX_SETPOINT, with_junk(loop_on ? pick_val(1, 1023) : 0, 10));
    write_reg(CFG_PROP_GAIN, with_junk(($urandom_range(3) == 0) ? pick_val(0, 65535)
                                                                 : $urandom_range(8192), 16));
    write_reg(CFG_INT_GAIN_STEP, ($urandom_range(4) == 0) ? pick_val(0, 32'hFFFFFFFF)
                                                          : $urandom_range(1 << 22));
    write_reg(CFG_DUTY_MAX, with_junk(pick_val(0, 23'h7FFFFF), DUTY_W));
    write_reg(CFG_MAX_CHANGE, with_junk(pick_val(0, 23'h7FFFFF), DUTY_W));
    write_reg(CFG_FILTER_ALPHA, with_junk(($urandom_range(4) == 0) ? pick_val(0, 17'h1FFFF)
                                                                   : pick_val(1, 65536), 17));
    write_reg(CFG_OFF_THRESHOLD, with_junk(($urandom_range(4) == 0) ? pick_val(0, 23'h7FFFFF)
                                                                    : pick_val(0, 65536),
                                           DUTY_W));
    if ($urandom_range(3) == 0) write_reg(CFG_UNUSED_IDX, $urandom());
  endtask

  task automatic run_phase(int n_items, int send_pct, int recv_pct, bit long_stall);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (long_stall) hold_req = 1'b1;
    repeat (n_items) queue_lux(pick_lux());
    drain(SETTLE_CYCLES);
  endtask

  initial begin
    int p;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_measured_lux = '0;
    out_stall = 1'b0;
    items_queued = 0;
    results_seen = 0;
    fail_count = 0;
    active_seen = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    lux_taken = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    setpoint_r = '0;
    kp_r = 16'd2867;
    ki_r = 32'd286331;
    duty_max_r = DUTY_FULL;
    slew_r = 23'd327680;
    alpha_r = 17'd6554;
    off_thr_r = 23'd32768;
    integ_acc = 0;
    smooth_duty = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // loop off from reset: decay of a zero duty
    @(posedge clk);
    queue_lux(16'h0000);
    queue_lux(16'hFFFF);
    drain(SETTLE_CYCLES);

    // ramp up, then a huge negative error hitting the lower clamp
    write_reg(CFG_LUX_SETPOINT, 500);
    @(posedge clk);
    queue_lux(16'h0000);
    queue_lux(16'hFFFF);
    queue_lux(500);
    queue_lux(500);
    repeat (3) queue_lux(16'h0000);
    drain(SETTLE_CYCLES);

    // decay with a zero step: duty holds
    write_reg(CFG_LUX_SETPOINT, 0);
    write_reg(CFG_OFF_THRESHOLD, 0);
    write_reg(CFG_FILTER_ALPHA, 0);
    @(posedge clk);
    queue_lux(100);
    drain(SETTLE_CYCLES);
    write_reg(CFG_FILTER_ALPHA, 1);
    @(posedge clk);
    queue_lux(100);
    queue_lux(200);
    drain(SETTLE_CYCLES);
    // alpha above one overshoots and floors at zero
    write_reg(CFG_FILTER_ALPHA, 32'hFFFFFFFF);
    @(posedge clk);
    queue_lux(300);
    drain(SETTLE_CYCLES);

    // every register at all ones: masking, integrator saturation, full clamps
    write_reg(CFG_LUX_SETPOINT, 32'hFFFFFFFF);
    write_reg(CFG_PROP_GAIN, 32'hFFFFFFFF);
    write_reg(CFG_INT_GAIN_STEP, 32'hFFFFFFFF);
    write_reg(CFG_DUTY_MAX, 32'hFFFFFFFF);
    write_reg(CFG_MAX_CHANGE, 32'hFFFFFFFF);
    write_reg(CFG_OFF_THRESHOLD, 32'hFFFFFFFF);
    write_reg(CFG_UNUSED_IDX, 32'hFFFFFFFF);
    @(posedge clk);
    queue_lux(16'h0000);
    queue_lux(16'h0000);
    queue_lux(16'hFFFF);
    queue_lux(1023);
    drain(SETTLE_CYCLES);

    // all limits and gains at zero
    write_reg(CFG_PROP_GAIN, 0);
    write_reg(CFG_INT_GAIN_STEP, 0);
    write_reg(CFG_DUTY_MAX, 0);
    write_reg(CFG_MAX_CHANGE, 0);
    write_reg(CFG_FILTER_ALPHA, 0);
    @(posedge clk);
    queue_lux(1);
    queue_lux(1023);
    drain(SETTLE_CYCLES);

    for (p = 0; p < RAND_PHASES; p++) begin
      random_setup((p % 5) != 4);
      case (p % 4)
        0: run_phase(PHASE_ITEMS, 0, 0, (p == 0) || (p == 8));
        1: run_phase(PHASE_ITEMS, 86, 0, 1'b0);
        2: run_phase(PHASE_ITEMS, 0, 86, 1'b0);
        default: run_phase(PHASE_ITEMS, 35, 35, 1'b0);
      endcase
    end

    drain(2 * SETTLE_CYCLES);
    $display("checked %0d result items over %0d register sets (%0d with the PI path on)",
             results_seen, RAND_PHASES + 6, active_seen);
    $display("idle patterns: none, sender, receiver, both; %0d mismatches", fail_count);
    if (fail_count == 0 && expected_duty.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d of %0d results seen", results_seen, items_queued);
    $display("Verification failed");
    $finish;
  end

endmodule
